// File: hw/rtl/f24amm_pkg.sv
// shared types and constants for the 24-bit float add/multiply/max pipeline
`default_nettype none

package f24amm_pkg;

   localparam int KIND_W    = 2;
   localparam int MANT_W    = 16;
   localparam int EXP_W     = 8;
   localparam int RAW_W     = 32;
   localparam int WIDE_W    = 34;
   localparam int XEXP_W    = 10;
   localparam int FEXP_W    = 11;
   localparam int MAG_W     = 31;
   localparam int SH_W      = 5;
   localparam int MAX_SHIFT = 17;

   localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MUL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MAX  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [MANT_W-1:0] a_mantissa;
      logic signed [EXP_W-1:0]  a_exponent;
      logic signed [MANT_W-1:0] b_mantissa;
      logic signed [EXP_W-1:0]  b_exponent;
   } req_type;

   typedef struct packed {
      logic                     is_max;
      logic signed [RAW_W-1:0]  raw;
      logic signed [XEXP_W-1:0] exp;
      logic signed [WIDE_W-1:0] va;
      logic signed [WIDE_W-1:0] vb;
      logic                     eq_exp;
      logic signed [MANT_W-1:0] a_mantissa;
      logic signed [EXP_W-1:0]  a_exponent;
      logic signed [MANT_W-1:0] b_mantissa;
      logic signed [EXP_W-1:0]  b_exponent;
   } s1_type;

   typedef struct packed {
      logic                     is_max;
      logic                     neg;
      logic [MAG_W-1:0]         mag;
      logic [SH_W-1:0]          shift;
      logic signed [XEXP_W-1:0] exp;
      logic signed [MANT_W-1:0] max_mantissa;
      logic signed [EXP_W-1:0]  max_exponent;
      logic                     second;
   } s2_type;

   typedef struct packed {
      logic signed [MANT_W-1:0] res_mantissa;
      logic signed [EXP_W-1:0]  res_exponent;
      logic                     exp_overflow;
      logic                     picked_second;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/f24amm_req_if.sv
// request channel: operation and two operands
`default_nettype none

interface f24amm_req_if;
   import f24amm_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic signed [MANT_W-1:0] a_mantissa;
   logic signed [EXP_W-1:0]  a_exponent;
   logic signed [MANT_W-1:0] b_mantissa;
   logic signed [EXP_W-1:0]  b_exponent;

   modport source (output valid, kind, a_mantissa, a_exponent, b_mantissa, b_exponent,
                   input ready);
   modport sink (input valid, kind, a_mantissa, a_exponent, b_mantissa, b_exponent,
                 output ready);
endinterface

`default_nettype wire

// File: hw/rtl/f24amm_rsp_if.sv
// response channel: result mantissa, exponent and flags
`default_nettype none

interface f24amm_rsp_if;
   import f24amm_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [MANT_W-1:0] res_mantissa;
   logic signed [EXP_W-1:0]  res_exponent;
   logic                     exp_overflow;
   logic                     picked_second;

   modport source (output valid, res_mantissa, res_exponent, exp_overflow, picked_second,
                   input ready);
   modport sink (input valid, res_mantissa, res_exponent, exp_overflow, picked_second,
                 output ready);
endinterface

`default_nettype wire

// File: hw/rtl/f24amm_front.sv
// stage 1: exponent difference, alignment shift, mantissa product, max operand scaling
`default_nettype none

module f24amm_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire f24amm_pkg::req_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output f24amm_pkg::s1_type    out_data
);
   import f24amm_pkg::*;

   logic                     valid_ff;
   s1_type                   data_ff;
   s1_type                   data_in;

   logic signed [EXP_W:0]    diff;
   logic                     a_ge;
   logic [EXP_W:0]           dmag;
   logic [SH_W-1:0]          dclamp;
   logic signed [MANT_W-1:0] small_m;
   logic signed [MANT_W-1:0] big_m;
   logic                     small_neg;
   logic [MANT_W-1:0]        small_mag;
   logic [MANT_W-1:0]        shifted;
   logic signed [MANT_W:0]   aligned;
   logic signed [MANT_W+1:0] sum;
   logic signed [RAW_W-1:0]  prod;
   logic                     is_mul;
   logic                     is_max;

   assign diff = {in_data.a_exponent[EXP_W-1], in_data.a_exponent}
               - {in_data.b_exponent[EXP_W-1], in_data.b_exponent};
   assign a_ge = ~diff[EXP_W];
   assign dmag = a_ge ? diff : (EXP_W+1)'(-diff);
   assign dclamp = (dmag > (EXP_W+1)'(MAX_SHIFT)) ? SH_W'(MAX_SHIFT) : dmag[SH_W-1:0];

   assign small_m   = a_ge ? in_data.b_mantissa : in_data.a_mantissa;
   assign big_m     = a_ge ? in_data.a_mantissa : in_data.b_mantissa;
   assign small_neg = small_m[MANT_W-1];
   assign small_mag = small_neg ? MANT_W'(-small_m) : $unsigned(small_m);
   // truncation toward zero: shift the magnitude, then restore the sign
   assign shifted   = (dmag >= (EXP_W+1)'(MANT_W)) ? '0 : (small_mag >> dmag[3:0]);
   assign aligned   = small_neg ? -$signed({1'b0, shifted}) : $signed({1'b0, shifted});
   assign sum       = (MANT_W+2)'(big_m) + (MANT_W+2)'(aligned);
   assign prod      = in_data.a_mantissa * in_data.b_mantissa;

   assign is_mul = (in_data.kind == KIND_MUL);
   assign is_max = !((in_data.kind == KIND_ADD) || (in_data.kind == KIND_MUL));

   always_comb begin
      data_in            = '0;
      data_in.is_max     = is_max;
      data_in.raw        = is_mul ? prod : RAW_W'(sum);
      data_in.exp        = is_mul ? (XEXP_W'(in_data.a_exponent) + XEXP_W'(in_data.b_exponent))
                                  : XEXP_W'(a_ge ? in_data.a_exponent : in_data.b_exponent);
      // operand with the larger exponent is scaled up, capped where it dominates anyway
      data_in.va         = WIDE_W'(in_data.a_mantissa) <<< (a_ge ? dclamp : SH_W'(0));
      data_in.vb         = WIDE_W'(in_data.b_mantissa) <<< (a_ge ? SH_W'(0) : dclamp);
      data_in.eq_exp     = (diff == '0);
      data_in.a_mantissa = in_data.a_mantissa;
      data_in.a_exponent = in_data.a_exponent;
      data_in.b_mantissa = in_data.b_mantissa;
      data_in.b_exponent = in_data.b_exponent;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/f24amm_scale.sv
// stage 2: magnitude and normalize shift count, max compare and select
`default_nettype none

module f24amm_scale (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire f24amm_pkg::s1_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output f24amm_pkg::s2_type    out_data
);
   import f24amm_pkg::*;

   logic             valid_ff;
   s2_type           data_ff;
   s2_type           data_in;

   logic             neg;
   logic [MAG_W-1:0] mag;
   logic [SH_W-1:0]  shift;
   logic             pick_a;

   assign neg = in_data.raw[RAW_W-1];
   assign mag = neg ? MAG_W'(-in_data.raw) : in_data.raw[MAG_W-1:0];

   // halvings needed so the magnitude fits in fifteen bits
   always_comb begin
      shift = '0;
      for (int i = MANT_W - 1; i < MAG_W; i++) begin
         if (mag[i]) begin
            shift = SH_W'(i - (MANT_W - 2));
         end
      end
   end

   assign pick_a = in_data.eq_exp ? (in_data.va >= in_data.vb) : (in_data.va > in_data.vb);

   always_comb begin
      data_in              = '0;
      data_in.is_max       = in_data.is_max;
      data_in.neg          = neg;
      data_in.mag          = mag;
      data_in.shift        = shift;
      data_in.exp          = in_data.exp;
      data_in.max_mantissa = pick_a ? in_data.a_mantissa : in_data.b_mantissa;
      data_in.max_exponent = pick_a ? in_data.a_exponent : in_data.b_exponent;
      data_in.second       = !pick_a;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/f24amm_pack.sv
// stage 3: normalize shift, exponent adjust and overflow, max result pass-through, output register
`default_nettype none

module f24amm_pack (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire f24amm_pkg::s2_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output f24amm_pkg::rsp_type   out_data
);
   import f24amm_pkg::*;

   logic                     valid_ff;
   rsp_type                  data_ff;
   rsp_type                  data_in;
   logic                     is_max_ff;

   logic [MANT_W-2:0]        mant_mag;
   logic signed [MANT_W-1:0] mant;
   logic signed [FEXP_W-1:0] exp_full;
   logic                     ovf;

   assign mant_mag = (MANT_W-1)'(in_data.mag >> in_data.shift);
   assign mant     = in_data.neg ? -$signed({1'b0, mant_mag}) : $signed({1'b0, mant_mag});
   assign exp_full = FEXP_W'(in_data.exp) + $signed({(FEXP_W-SH_W)'(0), in_data.shift});
   assign ovf      = (exp_full > FEXP_W'(127)) || (exp_full < -FEXP_W'(128));

   always_comb begin
      if (in_data.is_max) begin
         data_in.res_mantissa  = in_data.max_mantissa;
         data_in.res_exponent  = in_data.max_exponent;
         data_in.exp_overflow  = 1'b0;
         data_in.picked_second = in_data.second;
      end else begin
         data_in.res_mantissa  = mant;
         data_in.res_exponent  = exp_full[EXP_W-1:0];
         data_in.exp_overflow  = ovf;
         data_in.picked_second = 1'b0;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff   <= data_in;
         is_max_ff <= in_data.is_max;
      end
   end

   // normalized results never keep the most negative mantissa
   a_norm_mant: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !is_max_ff |-> data_ff.res_mantissa != -MANT_W'(32768))
      else $error("normalized mantissa out of range");

   a_max_no_ovf: assert property (@(posedge clock) disable iff (reset)
      valid_ff && is_max_ff |-> !data_ff.exp_overflow)
      else $error("overflow flagged on max");

   a_arith_first: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !is_max_ff |-> !data_ff.picked_second)
      else $error("picked_second set on add or multiply");

endmodule

`default_nettype wire

// File: hw/rtl/float24_add_mul_max_unit_core.sv
// top level of the 24-bit float add/multiply/max pipeline
//
//   channel | dir | handshake            | payload
//   req_ch  | in  | valid/ready          | kind, a_mantissa, a_exponent, b_mantissa, b_exponent
//   rsp_ch  | out | valid/ready          | res_mantissa, res_exponent, exp_overflow,
//           |     |                      | picked_second
//
// three register stages (front, scale, pack); a taken request is registered in each stage in turn,
// and rsp_ch.valid rises once its result sits in the pack stage's output register
// one request per cycle is accepted while rsp_ch.ready stays high
// each stage holds its item under back-pressure and takes a new one when it empties
// synchronous reset empties all stages; there is no other state
`default_nettype none

module float24_add_mul_max_unit_core (
   input  wire logic      clock,
   input  wire logic      reset,
   f24amm_req_if.sink     req_ch,
   f24amm_rsp_if.source   rsp_ch
);
   import f24amm_pkg::*;

   req_type req_data;
   s1_type  s1_data;
   s2_type  s2_data;
   rsp_type rsp_data;
   logic    s1_valid;
   logic    s1_ready;
   logic    s2_valid;
   logic    s2_ready;

   assign req_data.kind       = req_ch.kind;
   assign req_data.a_mantissa = req_ch.a_mantissa;
   assign req_data.a_exponent = req_ch.a_exponent;
   assign req_data.b_mantissa = req_ch.b_mantissa;
   assign req_data.b_exponent = req_ch.b_exponent;

   f24amm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_data   (req_data),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   f24amm_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   f24amm_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_data)
   );

   assign rsp_ch.res_mantissa  = rsp_data.res_mantissa;
   assign rsp_ch.res_exponent  = rsp_data.res_exponent;
   assign rsp_ch.exp_overflow  = rsp_data.exp_overflow;
   assign rsp_ch.picked_second = rsp_data.picked_second;

endmodule

`default_nettype wire

// File: sim/testbench.sv
// self-checking testbench for the 24-bit float add/multiply/max pipeline
`timescale 1ns / 1ps

module testbench;
   import f24amm_pkg::*;

   localparam int MANT_LIMIT   = 32767;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 113;
   localparam int TAIL_CYCLES  = 10;
   localparam int REPORT_FIRST = 10;

   class f24_result_board;
      rsp_type awaited[$];
      int      mismatches;
      int      checked;
      int      n_add, n_mul, n_max, n_ovf;

      // truncating division by 2^d, as repeated halving toward zero
      static function longint halve_toward_zero(longint m, int d);
         if (d > 20) return 0;
         return m / (longint'(1) << d);
      endfunction

      static function rsp_type f24_result_of(req_type r);
         int      am, ae, bm, be, e, lo, da, db;
         longint  m, va, vb;
         bit      take_a;
         rsp_type y;
         am = r.a_mantissa;
         ae = r.a_exponent;
         bm = r.b_mantissa;
         be = r.b_exponent;
         y  = '0;
         if (r.kind == KIND_ADD || r.kind == KIND_MUL) begin
            if (r.kind == KIND_ADD) begin
               if (ae >= be) begin
                  m = longint'(am) + halve_toward_zero(bm, ae - be);
                  e = ae;
               end else begin
                  m = halve_toward_zero(am, be - ae) + longint'(bm);
                  e = be;
               end
            end else begin
               m = longint'(am) * longint'(bm);
               e = ae + be;
            end
            while (m > MANT_LIMIT || m < -MANT_LIMIT) begin
               m = m / 2;
               e = e + 1;
            end
            y.res_mantissa = m[MANT_W-1:0];
            y.res_exponent = e[EXP_W-1:0];
            y.exp_overflow = (e > 127 || e < -128);
         end else begin
            // max, and the unused kind behaves the same
            if (ae == be) begin
               take_a = (am >= bm);
            end else begin
               lo = (ae < be) ? ae : be;
               da = ae - lo;
               db = be - lo;
               if (da > 17) da = 17;
               if (db > 17) db = 17;
               va = longint'(am) * (longint'(1) << da);
               vb = longint'(bm) * (longint'(1) << db);
               take_a = (va > vb);
            end
            y.res_mantissa  = take_a ? r.a_mantissa : r.b_mantissa;
            y.res_exponent  = take_a ? r.a_exponent : r.b_exponent;
            y.picked_second = !take_a;
         end
         return y;
      endfunction

      function void note_request(req_type r);
         rsp_type y;
         y = f24_result_of(r);
         awaited.push_back(y);
         if (r.kind == KIND_ADD) n_add++;
         else if (r.kind == KIND_MUL) n_mul++;
         else n_max++;
         if (y.exp_overflow) n_ovf++;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_FIRST)
               $display("unexpected result m=%0d e=%0d ovf=%0b sec=%0b",
                        got.res_mantissa, got.res_exponent, got.exp_overflow,
                        got.picked_second);
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (got.res_mantissa !== want.res_mantissa || got.res_exponent !== want.res_exponent
             || got.exp_overflow !== want.exp_overflow
             || got.picked_second !== want.picked_second) begin
            mismatches++;
            if (mismatches <= REPORT_FIRST)
               $display({"result %0d: expected m=%0d e=%0d ovf=%0b sec=%0b, ",
                         "got m=%0d e=%0d ovf=%0b sec=%0b"},
                        checked, want.res_mantissa, want.res_exponent, want.exp_overflow,
                        want.picked_second, got.res_mantissa, got.res_exponent,
                        got.exp_overflow, got.picked_second);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   send_idle_on = 1'b1;
   bit   recv_idle_on = 1'b1;
   int   cycles = 0;

   f24_result_board board = new();
   req_type         directed[$];

   f24amm_req_if req_ch();
   f24amm_rsp_if rsp_ch();

   float24_add_mul_max_unit_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  board.awaited.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int draw_gap(bit idle_on);
      if (!idle_on || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 14);
   endfunction

   function automatic req_type make_req(logic [KIND_W-1:0] kind, int am, int ae, int bm,
                                        int be);
      req_type r;
      r.kind       = kind;
      r.a_mantissa = MANT_W'(am);
      r.a_exponent = EXP_W'(ae);
      r.b_mantissa = MANT_W'(bm);
      r.b_exponent = EXP_W'(be);
      return r;
   endfunction

   function automatic logic signed [MANT_W-1:0] random_mantissa();
      case ($urandom_range(0, 7))
         0:       return MANT_W'(32767);
         1:       return MANT_W'(-32768);
         2:       return MANT_W'(int'($urandom_range(0, 16)) - 8);
         default: return MANT_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [EXP_W-1:0] random_exponent();
      case ($urandom_range(0, 5))
         0:       return EXP_W'(127);
         1:       return EXP_W'(-128);
         default: return EXP_W'($urandom);
      endcase
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(0, 19);
      if (pick < 7)       r.kind = KIND_ADD;
      else if (pick < 13) r.kind = KIND_MUL;
      else if (pick < 19) r.kind = KIND_MAX;
      else                r.kind = KIND_RSVD;
      r.a_mantissa = random_mantissa();
      r.b_mantissa = random_mantissa();
      r.a_exponent = random_exponent();
      // keep exponents close most of the time so alignment actually matters
      case ($urandom_range(0, 3))
         0:       r.b_exponent = random_exponent();
         1:       r.b_exponent = r.a_exponent;
         default: r.b_exponent = EXP_W'(int'(r.a_exponent) + int'($urandom_range(0, 48)) - 24);
      endcase
      return r;
   endfunction

   task automatic send_request(input req_type r);
      int gap;
      gap = draw_gap(send_idle_on);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.kind       = r.kind;
      req_ch.a_mantissa = r.a_mantissa;
      req_ch.a_exponent = r.a_exponent;
      req_ch.b_mantissa = r.b_mantissa;
      req_ch.b_exponent = r.b_exponent;
      req_ch.valid      = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(r);
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
   endtask

   // result side: random stalls, check every accepted result
   initial begin
      rsp_type got;
      int      gap;
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         gap = draw_gap(recv_idle_on);
         @(negedge clock);
         if (gap > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got.res_mantissa  = rsp_ch.res_mantissa;
         got.res_exponent  = rsp_ch.res_exponent;
         got.exp_overflow  = rsp_ch.exp_overflow;
         got.picked_second = rsp_ch.picked_second;
         board.check_result(got);
      end
   end

   initial begin
      int p, i;
      req_ch.valid      = 1'b0;
      req_ch.kind       = KIND_ADD;
      req_ch.a_mantissa = '0;
      req_ch.a_exponent = '0;
      req_ch.b_mantissa = '0;
      req_ch.b_exponent = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      directed.push_back(make_req(KIND_ADD, 0, 0, 0, 0));
      directed.push_back(make_req(KIND_ADD, 32767, 0, 32767, 0));
      directed.push_back(make_req(KIND_ADD, -32768, 0, -32768, 0));
      directed.push_back(make_req(KIND_ADD, -32768, 5, 0, 5));
      directed.push_back(make_req(KIND_ADD, 100, -128, 3, 127));
      directed.push_back(make_req(KIND_ADD, 32767, 127, 32767, 127));
      directed.push_back(make_req(KIND_ADD, -32768, 10, 12345, -10));
      directed.push_back(make_req(KIND_ADD, -32767, -11, 5, 10));
      directed.push_back(make_req(KIND_ADD, -32768, -128, -32768, -128));
      directed.push_back(make_req(KIND_MUL, 32767, 127, 32767, 127));
      directed.push_back(make_req(KIND_MUL, -32768, -128, -32768, -128));
      directed.push_back(make_req(KIND_MUL, -32768, 0, 32767, 0));
      directed.push_back(make_req(KIND_MUL, 0, -5, 5, 3));
      directed.push_back(make_req(KIND_MUL, 1, -100, 1, -29));
      directed.push_back(make_req(KIND_MUL, -1, 64, 1, 63));
      directed.push_back(make_req(KIND_MAX, 7, 3, 7, 3));
      directed.push_back(make_req(KIND_MAX, -5, 3, 9, 3));
      directed.push_back(make_req(KIND_MAX, 2, 3, 4, 2));
      directed.push_back(make_req(KIND_MAX, 1, 10, 32767, 0));
      directed.push_back(make_req(KIND_MAX, -1, 127, -32768, -128));
      directed.push_back(make_req(KIND_MAX, 1, 127, 32767, -128));
      directed.push_back(make_req(KIND_MAX, -32768, -128, 32767, 127));
      directed.push_back(make_req(KIND_RSVD, 3, 1, 3, 1));
      directed.push_back(make_req(KIND_RSVD, 6, 0, 3, 1));
      foreach (directed[k]) send_request(directed[k]);
      hold_until_drained();

      // phases: mixed idling, none at all, sender only, receiver only
      for (p = 0; p < 4; p++) begin
         send_idle_on = (p == 0 || p == 2);
         recv_idle_on = (p == 0 || p == 3);
         for (i = 0; i < PHASE_ITEMS; i++) send_request(random_request());
         hold_until_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("checked %0d results: %0d add, %0d multiply, %0d max requests",
               board.checked, board.n_add, board.n_mul, board.n_max);
      $display("%0d results with exponent overflow, %0d mismatches, %0d cycles",
               board.n_ovf, board.mismatches, cycles);
      if (board.mismatches == 0 && board.awaited.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/f24amm_pkg.sv
hw/rtl/f24amm_req_if.sv
hw/rtl/f24amm_rsp_if.sv
hw/rtl/f24amm_front.sv
hw/rtl/f24amm_scale.sv
hw/rtl/f24amm_pack.sv
hw/rtl/float24_add_mul_max_unit_core.sv
sim/testbench.sv
